### rtl/core/wavetable_oscillator_glide_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wavetable oscillator glide unit.
// Both forms are clocked on the given clock and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_GLIDE_UNIT_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_GLIDE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WOG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WOG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wog_pkg.sv
// ----------------------------------------------------------------------------
// wog_pkg
// Shared constants, codes and types of the wavetable oscillator glide unit.
// ----------------------------------------------------------------------------
package wog_pkg;

    localparam int NUM_WAVES   = 8;
    localparam int WAVE_LENGTH = 256;
    localparam int TABLE_SIZE  = NUM_WAVES * WAVE_LENGTH;
    localparam int TABLE_AW    = $clog2(TABLE_SIZE);
    localparam int IDX_W       = $clog2(WAVE_LENGTH);

    localparam int TARGET_W    = 31;
    localparam int DIV_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int WSEL_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int ADDR_W      = 11;
    localparam int DATA_W      = 8;
    localparam int SAMPLE_W    = 14;
    localparam int PHASE_W     = 32;

    localparam int DIV_STEPS   = TARGET_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int PROD_W      = (DATA_W + 1) + (GAIN_W + 1);
    localparam int OUT_SHIFT   = 10;

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(13421772);
    localparam logic [DIV_W-1:0]    DIV_RESET    = DIV_W'(1);
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(65535);
    localparam logic [WSEL_W-1:0]   WAVE_RESET   = '0;
    localparam logic                ENABLE_RESET = 1'b1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET  = 3'd0,
        CFG_DIVISOR = 3'd1,
        CFG_GAIN    = 3'd2,
        CFG_WAVE    = 3'd3,
        CFG_ENABLE  = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_UPDATE,
        S_PHASE,
        S_READ,
        S_MUL,
        S_OUT
    } t_state;

endpackage

### rtl/core/wavetable_oscillator_glide_unit.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_glide_unit
// Wavetable oscillator with glide. The input channel carries a command: a
// sample tick, or a write of one byte into the wave table. Only a tick gives
// a transfer on the output channel, a signed 14-bit sample; a write is stored
// in the cycle of its transfer and the block is ready again at once.
// An enabled tick passes through the bit-serial divider that moves the glide
// increment towards the target, then glide update, phase add, table read,
// gain multiply and output load. A disabled tick goes straight to the output
// load with a zero sample. One tick is worked on at a time: no new command
// is taken until its sample has been loaded into the output register.
// The output register holds a finished sample while the receiver stalls; the
// next tick may be taken meanwhile but waits before its own output load.
// Reset clears the glide and phase, restores the register defaults and
// empties the output; the wave table keeps its contents and must be written
// before it is played.
// ----------------------------------------------------------------------------
module wavetable_oscillator_glide_unit
    import wog_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic [ADDR_W-1:0]     i_table_address,
    input  logic [DATA_W-1:0]     i_table_data,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);

    `include "wavetable_oscillator_glide_unit_assert.svh"

    t_state                    r_state, n_state;
    logic [TARGET_W-1:0]       r_target;
    logic [DIV_W-1:0]          r_divisor;
    logic [GAIN_W-1:0]         r_gain;
    logic [WSEL_W-1:0]         r_wave;
    logic                      r_enable;
    logic [TARGET_W-1:0]       r_glide;
    logic [PHASE_W-1:0]        r_phase;
    logic                      r_out_valid;

    logic [DIV_W-1:0]          r_rem;
    logic [TARGET_W-1:0]       r_quo;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [DATA_W-1:0]         r_rd_data;

    logic [DATA_W-1:0]         r_mem [TABLE_SIZE];

    logic                      w_accept;
    logic                      w_tick;
    logic                      w_out_load;
    logic                      w_mem_we;
    logic [TABLE_AW-1:0]       w_rd_addr;
    logic [DIV_W-1:0]          w_div_eff;
    logic [PHASE_W-1:0]        w_diff;
    logic [PHASE_W-1:0]        w_diff_mag;
    logic [DIV_W+1:0]          w_trial;
    logic [PHASE_W-1:0]        w_q_signed;
    logic [PHASE_W-1:0]        w_glide_next;
    logic signed [DATA_W:0]    w_centred;
    logic signed [PROD_W-1:0]  w_prod;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    assign w_accept = i_in_valid && o_in_ready;
    assign w_tick   = w_accept && (i_command == CMD_TICK);
    assign w_mem_we = w_accept && (i_command == CMD_WRITE)
                      && (32'(i_table_address) < TABLE_SIZE);

    assign w_div_eff  = (r_divisor == '0) ? DIV_W'(1) : r_divisor;
    assign w_diff     = {1'b0, r_target} - {1'b0, r_glide};
    assign w_diff_mag = w_diff[PHASE_W-1] ? (~w_diff + PHASE_W'(1)) : w_diff;
    assign w_trial    = {1'b0, r_rem, r_quo[TARGET_W-1]} - {2'b00, w_div_eff};
    assign w_q_signed = r_neg ? (~{1'b0, r_quo} + PHASE_W'(1)) : {1'b0, r_quo};
    assign w_glide_next = {1'b0, r_glide} + w_q_signed;

    assign w_rd_addr = TABLE_AW'(32'(r_wave % NUM_WAVES) * WAVE_LENGTH
                                 + 32'(r_phase[PHASE_W-1 -: IDX_W]));

    assign w_centred = $signed({1'b0, r_rd_data}) - $signed((DATA_W+1)'(128));
    assign w_prod    = PROD_W'(w_centred) * PROD_W'($signed({1'b0, r_gain}));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_tick) begin
                    n_state = r_enable ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_PHASE;
            S_PHASE:  n_state = S_READ;
            S_READ:   n_state = S_MUL;
            S_MUL:    n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_OUT:   w_out_load = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= TARGET_RESET;
            r_divisor   <= DIV_RESET;
            r_gain      <= GAIN_RESET;
            r_wave      <= WAVE_RESET;
            r_enable    <= ENABLE_RESET;
            r_glide     <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARGET:  r_target  <= i_cfg_data[TARGET_W-1:0];
                    CFG_DIVISOR: r_divisor <= i_cfg_data[DIV_W-1:0];
                    CFG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_WAVE:    r_wave    <= i_cfg_data[WSEL_W-1:0];
                    CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_UPDATE) begin
                r_glide <= w_glide_next[TARGET_W-1:0];
            end
            if (r_state == S_PHASE) begin
                r_phase <= r_phase + PHASE_W'(r_glide);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider, multiplier and output data
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_rem  <= '0;
            r_quo  <= w_diff_mag[TARGET_W-1:0];
            r_neg  <= w_diff[PHASE_W-1];
            r_cnt  <= '0;
            r_prod <= '0;
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!w_trial[DIV_W+1]) begin
                r_rem <= w_trial[DIV_W-1:0];
                r_quo <= {r_quo[TARGET_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DIV_W-2:0], r_quo[TARGET_W-1]};
                r_quo <= {r_quo[TARGET_W-2:0], 1'b0};
            end
        end else if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if (w_out_load) begin
            r_sample <= r_prod[OUT_SHIFT +: SAMPLE_W];
        end
    end

    // Wave table
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[TABLE_AW'(i_table_address)] <= i_table_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample;

    `WOG_ASSERT_NEXT(a_disabled_tick, i_clk, i_rst_n,
        w_tick && !r_enable, (r_state == S_OUT) && (r_prod == '0),
        "Disabled tick did not go straight to output with a zero sample")
    `WOG_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n,
        r_state == S_DIV, r_rem < w_div_eff,
        "Divider remainder is not below the divisor")
    `WOG_ASSERT_NEXT(a_write_stays_idle, i_clk, i_rst_n,
        w_accept && (i_command == CMD_WRITE), r_state == S_IDLE,
        "Table write left the idle state")
    `WOG_ASSERT_NEXT(a_div_length, i_clk, i_rst_n,
        (r_state == S_DIV) && (r_cnt == CNT_LAST), r_state == S_UPDATE,
        "Divider did not finish after its last step")

endmodule

### verif/wavetable_oscillator_glide_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for wavetable_oscillator_glide_unit
// Drives table writes and sample ticks through the input channel and checks
// every output sample against a cycle-free model of the oscillator. The model
// covers the glide step, phase accumulator, table lookup and gain stage. The
// run goes through several register settings and flow-control patterns,
// including a long receiver hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module wavetable_oscillator_glide_unit_tb;
    import wog_pkg::*;

    localparam int          HALF_PERIOD   = 4;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          GAIN_SHIFT    = 18;
    localparam int          CENTRE        = 128;
    localparam int          RANDOM_PHASES = 14;
    localparam int          PHASE_ITEMS   = 60;
    localparam int          HOLD_PHASE    = 4;
    localparam int unsigned HOLD_CYCLES   = 500;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

    class osc_sample_checker;
        logic [TARGET_W-1:0] target_inc;
        logic [DIV_W-1:0]    glide_div;
        logic [GAIN_W-1:0]   gain;
        logic [WSEL_W-1:0]   wave_sel;
        logic                enabled;
        logic [PHASE_W-1:0]  glide_inc;
        logic [PHASE_W-1:0]  phase_acc;
        logic [DATA_W-1:0]   wave_mem [TABLE_SIZE];
        bit                  written [TABLE_SIZE];
        sample_t             pending_samples [$];
        int unsigned         ticks;
        int unsigned         table_writes;
        int unsigned         compared;
        int unsigned         mismatches;

        function new();
            target_inc   = TARGET_RESET;
            glide_div    = DIV_RESET;
            gain         = GAIN_RESET;
            wave_sel     = WAVE_RESET;
            enabled      = ENABLE_RESET;
            glide_inc    = '0;
            phase_acc    = '0;
            ticks        = 0;
            table_writes = 0;
            compared     = 0;
            mismatches   = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
            case (r)
                CFG_TARGET:  target_inc = v[TARGET_W-1:0];
                CFG_DIVISOR: glide_div  = v[DIV_W-1:0];
                CFG_GAIN:    gain       = v[GAIN_W-1:0];
                CFG_WAVE:    wave_sel   = v[WSEL_W-1:0];
                CFG_ENABLE:  enabled    = v[0];
                default: ;
            endcase
        endfunction

        function bit wave_loaded(logic [WSEL_W-1:0] w);
            for (int k = 0; k < WAVE_LENGTH; k++) begin
                if (!written[{w, IDX_W'(k)}]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function sample_t next_sample();
            longint divisor;
            longint diff;
            longint stepped;
            longint product;
            logic [DATA_W-1:0] entry;
            divisor   = (glide_div == '0) ? 64'sd1 : longint'(glide_div);
            diff      = longint'(target_inc) - longint'(glide_inc);
            stepped   = longint'(glide_inc) + diff / divisor;
            glide_inc = stepped[PHASE_W-1:0];
            phase_acc = phase_acc + glide_inc;
            entry     = wave_mem[{wave_sel, phase_acc[PHASE_W-1 -: IDX_W]}];
            product   = (longint'(entry) - CENTRE) * 256 * longint'(gain);
            return sample_t'(product >>> GAIN_SHIFT);
        endfunction

        function void note_transfer(logic cmd, logic [ADDR_W-1:0] addr,
                                    logic [DATA_W-1:0] data);
            if (cmd == CMD_WRITE) begin
                table_writes++;
                if (addr < TABLE_SIZE) begin
                    wave_mem[addr] = data;
                    written[addr]  = 1'b1;
                end
            end else begin
                ticks++;
                if (enabled) pending_samples.push_back(next_sample());
                else pending_samples.push_back('0);
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_sample(sample_t got);
            sample_t want;
            if (pending_samples.size() == 0) begin
                flag_mismatch($sformatf("sample %0d arrived with none outstanding", got));
            end else begin
                want = pending_samples.pop_front();
                compared++;
                if (got !== want) begin
                    flag_mismatch($sformatf("sample %0d: got %0d, predicted %0d",
                                            compared, got, want));
                end
            end
        endtask
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic                  i_command       = CMD_TICK;
    logic [ADDR_W-1:0]     i_table_address = '0;
    logic [DATA_W-1:0]     i_table_data    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    sample_t               o_sample_out;

    osc_sample_checker sb;
    int unsigned       send_idle_pct  = 0;
    int unsigned       stall_pct      = 0;
    int unsigned       rx_hold        = 0;
    int unsigned       cycle_count    = 0;
    int unsigned       settings_count = 0;

    wavetable_oscillator_glide_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_table_address (i_table_address),
        .i_table_data    (i_table_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_out    (o_sample_out)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", CYCLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_sample(o_sample_out);
    end

    function void set_flow(flow_t f);
        case (f)
            FLOW_FREE:        begin send_idle_pct = 0;  stall_pct = 0;  end
            FLOW_SEND_GAPS:   begin send_idle_pct = 69; stall_pct = 0;  end
            FLOW_RECV_STALLS: begin send_idle_pct = 0;  stall_pct = 69; end
            default:          begin send_idle_pct = 31; stall_pct = 31; end
        endcase
    endfunction

    task automatic send_item(logic cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_table_address <= addr;
        i_table_data    <= data;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_transfer(cmd, addr, data);
    endtask

    task automatic send_tick(int unsigned count);
        repeat (count) send_item(CMD_TICK, ADDR_W'($urandom), DATA_W'($urandom));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(posedge i_clk);
        sb.set_reg(r, v);
    endtask

    task automatic configure(logic [TARGET_W-1:0] tgt, logic [DIV_W-1:0] dv,
                             logic [GAIN_W-1:0] gn, logic [WSEL_W-1:0] ws, logic en);
        write_reg(CFG_TARGET,  CFG_DATA_W'(tgt));
        write_reg(CFG_DIVISOR, CFG_DATA_W'(dv));
        write_reg(CFG_GAIN,    CFG_DATA_W'(gn));
        write_reg(CFG_WAVE,    CFG_DATA_W'(ws));
        write_reg(CFG_ENABLE,  CFG_DATA_W'(en));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_count++;
    endtask

    // Entries 0 and 1 of each wave hold the full-scale bytes and entry 2 the
    // centre, so opening ticks at default increment hit both output extremes.
    task automatic load_wave(logic [WSEL_W-1:0] w, bit with_ticks);
        logic [DATA_W-1:0] entry;
        for (int k = 0; k < WAVE_LENGTH; k++) begin
            entry = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : (k == 2) ? 8'h80
                  : DATA_W'($urandom);
            send_item(CMD_WRITE, {w, IDX_W'(k)}, entry);
            if (with_ticks && (k % 4 == 3)) send_tick(1);
        end
    endtask

    task automatic random_phase(int unsigned phase_no);
        logic [TARGET_W-1:0] tgt;
        logic [DIV_W-1:0]    dv;
        logic [GAIN_W-1:0]   gn;
        logic [WSEL_W-1:0]   ws;
        logic                en;
        case ($urandom_range(4))
            0:       tgt = '0;
            1:       tgt = '1;
            2:       tgt = TARGET_W'($urandom_range(1 << 20));
            default: tgt = TARGET_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       dv = '0;
            1:       dv = DIV_W'(1);
            2:       dv = '1;
            3:       dv = DIV_W'($urandom_range(2, 16));
            default: dv = DIV_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       gn = '0;
            1:       gn = '1;
            default: gn = GAIN_W'($urandom);
        endcase
        ws = ($urandom_range(1) == 1 && sb.wave_loaded('1)) ? '1 : '0;
        en = ($urandom_range(6) != 0);
        configure(tgt, dv, gn, ws, en);
        set_flow(flow_t'(phase_no % 4));
        if (phase_no == HOLD_PHASE) rx_hold = HOLD_CYCLES;
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 70) send_tick(1);
            else send_item(CMD_WRITE, ADDR_W'($urandom), DATA_W'($urandom));
        end
        drain();
    endtask

    initial begin
        sb = new();
        set_flow(FLOW_FREE);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_wave('0, 1'b0);
        send_tick(3);
        send_item(CMD_WRITE, '1, '1);
        send_item(CMD_WRITE, '0, '0);
        drain();

        configure(TARGET_RESET, DIV_RESET, GAIN_RESET, WAVE_RESET, 1'b0);
        send_tick(2);
        send_item(CMD_WRITE, ADDR_W'(3), 8'h5A);
        send_tick(1);
        drain();

        configure('1, '0, '0, '0, 1'b1);
        send_tick(2);
        drain();

        configure('0, '1, '1, '0, 1'b1);
        send_tick(2);
        drain();

        configure(TARGET_W'(1000), DIV_W'(3), GAIN_W'(32768), '0, 1'b1);
        send_tick(2);
        drain();

        set_flow(FLOW_BOTH);
        load_wave('1, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

        if (sb.pending_samples.size() != 0) begin
            sb.flag_mismatch($sformatf("%0d predicted samples never arrived",
                                       sb.pending_samples.size()));
        end
        $display("Ran %0d ticks and %0d table writes over %0d register settings.",
                 sb.ticks, sb.table_writes, settings_count);
        $display("Compared %0d samples under free, gapped, stalled and held-off flow.",
                 sb.compared);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
